[design/hpce_pkg.sv]
// Shared types, constants and helpers for the hex page command extractor.
`timescale 1ns / 1ps
`default_nettype none

package hpce_pkg;

    localparam int CFG_W     = 64;
    localparam int CFG_IDX_W = 3;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PAGE_MARK = 3'd0,
        CFG_BEGIN_TAG = 3'd1,
        CFG_BEGIN_LEN = 3'd2,
        CFG_END_TAG   = 3'd3,
        CFG_END_LEN   = 3'd4
    } cfg_idx_t;

    // Reset values of the configuration registers ("<Cmd>" and "</Cmd>")
    localparam logic [7:0]  PAGE_MARK_RST = 8'h22;
    localparam logic [63:0] BEGIN_TAG_RST = 64'h0000_003E_646D_433C;
    localparam logic [3:0]  BEGIN_LEN_RST = 4'd5;
    localparam logic [63:0] END_TAG_RST   = 64'h0000_3E64_6D43_2F3C;
    localparam logic [3:0]  END_LEN_RST   = 4'd6;

    // Lowest byte that counts as a digit inside a page
    localparam logic [7:0] HEX_MIN = 8'h30;

    // Result kinds
    localparam logic EV_CMD      = 1'b0;
    localparam logic EV_PAGE_END = 1'b1;

    // Front end result for one word
    typedef struct packed {
        logic       page_end;
        logic       dec_valid;
        logic [7:0] dec;
    } front_t;

    // Command byte leaving the matcher
    typedef struct packed {
        logic       valid;
        logic [7:0] data;
    } emit_t;

    // Hex digit value; anything not 0-9, a-f, A-F reads as zero
    function automatic logic [3:0] nibble_of(input logic [7:0] c);
        logic [7:0] v;
        v = 8'h00;
        if (c >= 8'h30 && c <= 8'h39) begin
            v = c - 8'h30;
        end
        else if (c >= 8'h61 && c <= 8'h66) begin
            v = c - 8'h57;
        end
        else if (c >= 8'h41 && c <= 8'h46) begin
            v = c - 8'h37;
        end
        return v[3:0];
    endfunction

endpackage

`default_nettype wire

[design/hpce_in_if.sv]
// Input channel: one received link byte per word.
`timescale 1ns / 1ps
`default_nettype none

interface hpce_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

`default_nettype wire

[design/hpce_out_if.sv]
// Output channel: command byte or page-end event per word.
`timescale 1ns / 1ps
`default_nettype none

interface hpce_out_if;
    logic       valid;
    logic       ready;
    logic       event_kind;
    logic [7:0] cmd_byte;

    modport source (output valid, output event_kind, output cmd_byte, input ready);
    modport sink   (input valid, input event_kind, input cmd_byte, output ready);
endinterface

`default_nettype wire

[design/hpce_front.sv]
// Page tracking and hex digit pairing.
`timescale 1ns / 1ps
`default_nettype none

module hpce_front import hpce_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       take,
    input  wire logic [7:0] rx_byte,
    input  wire logic [7:0] page_mark,
    output front_t          fr
);

    logic       page_active_reg, page_active_next;
    logic       have_half_reg, have_half_next;
    logic [3:0] first_digit_reg, first_digit_next;
    logic [3:0] nib;

    assign nib = nibble_of(rx_byte);

    always_comb
    begin
        page_active_next = page_active_reg;
        have_half_next   = have_half_reg;
        first_digit_next = first_digit_reg;
        fr               = '0;
        if (take)
        begin
            if (rx_byte == page_mark)
            begin
                page_active_next = ~page_active_reg;
                fr.page_end      = page_active_reg;
            end
            else if (page_active_reg && rx_byte >= HEX_MIN)
            begin
                if (!have_half_reg)
                begin
                    first_digit_next = nib;
                    have_half_next   = 1'b1;
                end
                else
                begin
                    have_half_next = 1'b0;
                    fr.dec_valid   = 1'b1;
                    fr.dec         = {first_digit_reg, nib};
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            page_active_reg <= 1'b0;
            have_half_reg   <= 1'b0;
            first_digit_reg <= 4'h0;
        end
        else
        begin
            page_active_reg <= page_active_next;
            have_half_reg   <= have_half_next;
            first_digit_reg <= first_digit_next;
        end
    end

endmodule

`default_nettype wire

[design/hpce_matcher.sv]
// Begin/end tag matcher and command tracking.
`timescale 1ns / 1ps
`default_nettype none

module hpce_matcher import hpce_pkg::*;
#(
    parameter int MAX_TAG_LEN = 8
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire front_t      fr,
    input  wire logic [63:0] begin_tag,
    input  wire logic [3:0]  begin_len,
    input  wire logic [63:0] end_tag,
    input  wire logic [3:0]  end_len,
    output emit_t            em
);

    localparam int POS_W = $clog2(MAX_TAG_LEN);
    localparam int LEN_W = $clog2(MAX_TAG_LEN + 1);

    logic             in_command_reg, in_command_next;
    logic [POS_W-1:0] match_pos_reg, match_pos_next;
    logic [7:0]       match_buf [MAX_TAG_LEN];

    logic [63:0]      sel_tag;
    logic [3:0]       sel_len;
    logic [LEN_W-1:0] len_eff;
    logic [LEN_W-1:0] pos_inc;
    logic [7:0]       tb  [MAX_TAG_LEN];
    logic [7:0]       cur [MAX_TAG_LEN];
    logic [MAX_TAG_LEN-1:0] miss;
    logic             buf_we;
    logic             hit;

    assign sel_tag = in_command_reg ? end_tag : begin_tag;
    assign sel_len = in_command_reg ? end_len : begin_len;

    // Zero length acts as one, long lengths clamp to the buffer depth
    always_comb
    begin
        if (sel_len == 4'd0)
        begin
            len_eff = LEN_W'(1);
        end
        else if (int'(sel_len) > MAX_TAG_LEN)
        begin
            len_eff = LEN_W'(MAX_TAG_LEN);
        end
        else
        begin
            len_eff = LEN_W'(sel_len);
        end
    end

    // Compare view: the byte arriving now replaces the entry it is written to
    for (genvar i = 0; i < MAX_TAG_LEN; i++)
    begin : g_cmp
        if (i < 8)
        begin : g_tb
            assign tb[i] = sel_tag[8*i +: 8];
        end
        else
        begin : g_tb_zero
            assign tb[i] = 8'h00;
        end
        assign cur[i]  = (POS_W'(i) == match_pos_reg) ? fr.dec : match_buf[i];
        assign miss[i] = (LEN_W'(i) < len_eff) && (cur[i] != tb[i]);
    end

    assign pos_inc = LEN_W'(match_pos_reg) + LEN_W'(1);

    always_comb
    begin
        match_pos_next  = match_pos_reg;
        in_command_next = in_command_reg;
        buf_we          = 1'b0;
        hit             = 1'b0;
        em              = '0;
        if (fr.dec_valid)
        begin
            if (match_pos_reg == '0)
            begin
                if (fr.dec == tb[0])
                begin
                    buf_we         = 1'b1;
                    match_pos_next = POS_W'(1);
                end
            end
            else if (int'(match_pos_reg) >= MAX_TAG_LEN)
            begin
                match_pos_next = '0;
            end
            else
            begin
                buf_we = 1'b1;
                if (pos_inc < len_eff)
                begin
                    match_pos_next = pos_inc[POS_W-1:0];
                end
                else
                begin
                    match_pos_next = '0;
                    hit            = ~|miss;
                end
            end

            if (in_command_reg)
            begin
                if (hit)
                begin
                    in_command_next = 1'b0;
                end
                else
                begin
                    em.valid = 1'b1;
                    em.data  = fr.dec;
                end
            end
            else if (hit)
            begin
                in_command_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_command_reg <= 1'b0;
            match_pos_reg  <= '0;
        end
        else
        begin
            in_command_reg <= in_command_next;
            match_pos_reg  <= match_pos_next;
        end
    end

    // Tag byte store, written at the current match position
    always_ff @(posedge clk)
    begin
        if (buf_we)
        begin
            match_buf[match_pos_reg] <= fr.dec;
        end
    end

`ifndef SYNTHESIS
    a_pos_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        int'(match_pos_reg) < MAX_TAG_LEN)
        else $error("match position beyond tag buffer");

    a_emit_in_cmd: assert property (@(posedge clk) disable iff (!rst_n)
        em.valid |-> in_command_reg)
        else $error("command byte emitted outside a command");

    a_pos_idle: assert property (@(posedge clk) disable iff (!rst_n)
        !fr.dec_valid |=> $stable(match_pos_reg) && $stable(in_command_reg))
        else $error("matcher state moved without a decoded byte");
`endif

endmodule

`default_nettype wire

[design/hex_page_command_extractor.sv]
// Top level of the hex page command extractor.
`timescale 1ns / 1ps
`default_nettype none

// Hex page command extractor. Takes one link byte per word on byte_ch and
// delivers command bytes and page-end events on event_ch. A page-mark byte
// toggles the page; closing it yields an event with event_kind 1 and
// cmd_byte 0. Inside a page, bytes of 0x30 and up pair into hex-decoded
// bytes; between the begin tag and the end tag every decoded byte except the
// one completing the end tag comes out with event_kind 0. Most words give no
// result and simply drop out.
// Timing: one word per clock while the result register is not held. Each word
// passes an input register, single-pass combinational logic (page/digit
// tracking plus a MAX_TAG_LEN-wide parallel tag compare) and then a result
// register. The only stall is a held result register: while
// event_ch is full and not taken, the input register holds and byte_ch
// ready drops once it is occupied.
// Configuration: cfg_we writes register cfg_index (0 page_mark, 1 begin_tag,
// 2 begin_len, 3 end_tag, 4 end_len) with cfg_wdata; other indexes are
// ignored. Write only while the block is idle. MAX_TAG_LEN sets the tag
// buffer depth; longer tag lengths clamp to it.

module hex_page_command_extractor import hpce_pkg::*;
#(
    parameter int MAX_TAG_LEN = 8
)
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    hpce_in_if.sink                   byte_ch,
    hpce_out_if.source                event_ch,
    input  wire logic                 cfg_we,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [CFG_W-1:0]     cfg_wdata
);

    // Configuration registers
    logic [7:0]  page_mark_reg;
    logic [63:0] begin_tag_reg;
    logic [3:0]  begin_len_reg;
    logic [63:0] end_tag_reg;
    logic [3:0]  end_len_reg;

    // Input register
    logic        s1_valid_reg;
    logic [7:0]  s1_byte_reg;

    // Result register
    logic        out_valid_reg;
    logic        out_kind_reg;
    logic [7:0]  out_byte_reg;

    logic        out_free;
    logic        fire;
    logic        in_take;
    logic        res_valid;
    front_t      fr;
    emit_t       em;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            page_mark_reg <= PAGE_MARK_RST;
            begin_tag_reg <= BEGIN_TAG_RST;
            begin_len_reg <= BEGIN_LEN_RST;
            end_tag_reg   <= END_TAG_RST;
            end_len_reg   <= END_LEN_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_idx_t'(cfg_index))
                CFG_PAGE_MARK: page_mark_reg <= cfg_wdata[7:0];
                CFG_BEGIN_TAG: begin_tag_reg <= cfg_wdata;
                CFG_BEGIN_LEN: begin_len_reg <= cfg_wdata[3:0];
                CFG_END_TAG:   end_tag_reg   <= cfg_wdata;
                CFG_END_LEN:   end_len_reg   <= cfg_wdata[3:0];
                default:       ;
            endcase
        end
    end

    // Handshake: the word in the input register is processed when the
    // result register is empty or being drained this cycle.
    assign out_free      = !out_valid_reg || event_ch.ready;
    assign fire          = s1_valid_reg && out_free;
    assign byte_ch.ready = !s1_valid_reg || fire;
    assign in_take       = byte_ch.valid && byte_ch.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (in_take)
        begin
            s1_valid_reg <= 1'b1;
        end
        else if (fire)
        begin
            s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            s1_byte_reg <= byte_ch.rx_byte;
        end
    end

    hpce_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .take      (fire),
        .rx_byte   (s1_byte_reg),
        .page_mark (page_mark_reg),
        .fr        (fr)
    );

    hpce_matcher #(
        .MAX_TAG_LEN (MAX_TAG_LEN)
    ) u_matcher (
        .clk       (clk),
        .rst_n     (rst_n),
        .fr        (fr),
        .begin_tag (begin_tag_reg),
        .begin_len (begin_len_reg),
        .end_tag   (end_tag_reg),
        .end_len   (end_len_reg),
        .em        (em)
    );

    // Page end and command byte never occur on the same word
    assign res_valid = fr.page_end || em.valid;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            out_valid_reg <= fire && res_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire && res_valid)
        begin
            out_kind_reg <= fr.page_end ? EV_PAGE_END : EV_CMD;
            out_byte_reg <= fr.page_end ? 8'h00 : em.data;
        end
    end

    assign event_ch.valid      = out_valid_reg;
    assign event_ch.event_kind = out_kind_reg;
    assign event_ch.cmd_byte   = out_byte_reg;

`ifndef SYNTHESIS
    a_page_end_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_kind_reg == EV_PAGE_END |-> out_byte_reg == 8'h00)
        else $error("page end carries a nonzero byte");

    a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && !out_free |=> s1_valid_reg && $stable(s1_byte_reg))
        else $error("input word lost during stall");

    a_result_loaded: assert property (@(posedge clk) disable iff (!rst_n)
        fire && res_valid |=> out_valid_reg)
        else $error("result dropped");
`endif

endmodule

`default_nettype wire

[tb/tb.sv]
// Testbench for the hex page command extractor: directed table, then random page frames.
`timescale 1ns / 1ps

module tb;
    import hpce_pkg::*;

    localparam int TAG_DEPTH = 8;
    // Index with no register behind it; writes to it must change nothing
    localparam logic [CFG_IDX_W-1:0] CFG_UNMAPPED = 3'd6;
    // Cycles to let in-flight words fall through before touching registers
    localparam int SETTLE_CYCLES = 4;
    localparam int RANDOM_PHASES = 10;
    localparam int WORDS_PER_PHASE = 150;

    // One predicted outcome of a word; hit = a result word is due
    typedef struct packed {
        logic       hit;
        logic       kind;
        logic [7:0] data;
    } outcome_t;

    typedef struct packed {
        logic [7:0]  mark;
        logic [63:0] open_tag;
        logic [3:0]  open_len;
        logic [63:0] close_tag;
        logic [3:0]  close_len;
    } setting_t;

    // Directed row: the byte, and a hand-written result where one is obvious
    typedef struct packed {
        logic [7:0] b;
        logic       typed;
        outcome_t   want;
    } row_t;

    localparam outcome_t NO_EVENT    = '{1'b0, EV_CMD, 8'h00};
    localparam outcome_t PAGE_END_EV = '{1'b1, EV_PAGE_END, 8'h00};
    localparam outcome_t CMD_FF      = '{1'b1, EV_CMD, 8'hFF};

    localparam int DIR_ROWS  = 23;
    // Registers are reprogrammed before this row
    localparam int SETUP_ROW = 15;

    // Rows up to SETUP_ROW run on the reset values: open a page, send "<Cmd>"
    // as hex (mixed case), deliver 0xFF, drop a low byte, close the page.
    // After that the page mark is 0xFF, the end tag is a single 0x00 with
    // length 0 and the begin tag is clamped from length 15. The command
    // carries over the page end; a non-hex digit reads as zero; the 1-byte
    // end tag only hits on the byte after its first character.
    row_t dir_plan [DIR_ROWS] = '{
        '{8'h22, 1'b1, NO_EVENT},
        '{"3",   1'b0, NO_EVENT},
        '{"C",   1'b0, NO_EVENT},
        '{"4",   1'b0, NO_EVENT},
        '{"3",   1'b0, NO_EVENT},
        '{"6",   1'b0, NO_EVENT},
        '{"d",   1'b0, NO_EVENT},
        '{"6",   1'b0, NO_EVENT},
        '{"4",   1'b0, NO_EVENT},
        '{"3",   1'b0, NO_EVENT},
        '{"E",   1'b0, NO_EVENT},
        '{"F",   1'b0, NO_EVENT},
        '{"F",   1'b1, CMD_FF},
        '{8'h00, 1'b1, NO_EVENT},
        '{8'h22, 1'b1, PAGE_END_EV},
        '{8'hFF, 1'b1, NO_EVENT},
        '{"Z",   1'b0, NO_EVENT},
        '{"7",   1'b0, NO_EVENT},
        '{"0",   1'b0, NO_EVENT},
        '{"0",   1'b0, NO_EVENT},
        '{"0",   1'b0, NO_EVENT},
        '{"1",   1'b0, NO_EVENT},
        '{8'hFF, 1'b1, PAGE_END_EV}
    };

    logic clk = 1'b0;
    logic rst_n;
    logic cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0] cfg_wdata;

    hpce_in_if  in_ch ();
    hpce_out_if out_ch ();

    hex_page_command_extractor #(.MAX_TAG_LEN(TAG_DEPTH)) DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .byte_ch   (in_ch),
        .event_ch  (out_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    always #5 clk = ~clk;

    // ---------------------------------------------------------------
    // Predictor: mirrored registers and extractor state
    // ---------------------------------------------------------------
    logic [7:0]  mark_cfg;
    logic [63:0] open_tag;
    logic [3:0]  open_len;
    logic [63:0] close_tag;
    logic [3:0]  close_len;

    logic       pg_open;
    logic       half_held;
    logic [3:0] hi_nib;
    logic       cmd_open;
    logic [3:0] mpos;
    logic [7:0] mbuf [TAG_DEPTH];

    outcome_t pending_events [$];
    int  mismatches = 0;
    int  words_sent = 0;
    logic idle_on = 1'b1;

    // Low nibble of the ASCII code carries the value: '0'..'9' directly,
    // 'a'..'f' and 'A'..'F' both start at 1 and need +9. Anything else is 0.
    function automatic logic [3:0] digit_value(input logic [7:0] c);
        if (c >= "0" && c <= "9")
            return c[3:0];
        if ((c >= "a" && c <= "f") || (c >= "A" && c <= "F"))
            return c[3:0] + 4'd9;
        return 4'd0;
    endfunction

    function automatic int tag_span(input logic [3:0] len);
        if (len == 4'd0)
            return 1;
        if (len > TAG_DEPTH)
            return TAG_DEPTH;
        return int'(len);
    endfunction

    // Shared matcher: arms on the first tag byte, then collects bytes blindly
    // until the span is full and compares once; the position clears either way.
    function automatic logic tag_seen(input logic [7:0] b, input logic [63:0] tag,
                                      input logic [3:0] len);
        int  span;
        logic same;
        span = tag_span(len);
        if (mpos == 4'd0)
        begin
            if (b == tag[7:0])
            begin
                mbuf[0] = b;
                mpos = 4'd1;
            end
            return 1'b0;
        end
        if (mpos >= TAG_DEPTH)
        begin
            mpos = 4'd0;
            return 1'b0;
        end
        mbuf[mpos] = b;
        mpos = mpos + 4'd1;
        if (int'(mpos) < span)
            return 1'b0;
        same = 1'b1;
        for (int i = 0; i < span; i++)
        begin
            if (mbuf[i] != tag[8*i +: 8])
                same = 1'b0;
        end
        mpos = 4'd0;
        return same;
    endfunction

    function automatic outcome_t decode_word(input logic [7:0] b);
        outcome_t r;
        logic [7:0] dec;
        r = NO_EVENT;
        if (b == mark_cfg)
        begin
            pg_open = !pg_open;
            if (!pg_open)
                r = PAGE_END_EV;
            return r;
        end
        if (!pg_open || b < HEX_MIN)
            return r;
        if (!half_held)
        begin
            hi_nib = digit_value(b);
            half_held = 1'b1;
            return r;
        end
        half_held = 1'b0;
        dec = {hi_nib, digit_value(b)};
        if (cmd_open)
        begin
            // Only the byte that completes the end tag is held back
            if (tag_seen(dec, close_tag, close_len))
                cmd_open = 1'b0;
            else
                r = '{1'b1, EV_CMD, dec};
        end
        else if (tag_seen(dec, open_tag, open_len))
        begin
            cmd_open = 1'b1;
        end
        return r;
    endfunction

    task automatic report_fault(input string msg);
        mismatches++;
        if (mismatches <= 10)
            $display("%0t: %s", $realtime, msg);
    endtask

    // ---------------------------------------------------------------
    // Byte channel driver: optional gap, then hold the word until taken
    // ---------------------------------------------------------------
    task automatic put_word(input logic [7:0] b, input logic typed, input outcome_t want);
        int gap;
        outcome_t got;
        logic counts;
        if (idle_on && $urandom_range(0, 4) == 0)
        begin
            gap = $urandom_range(1, 10);
            in_ch.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_ch.valid   <= 1'b1;
        in_ch.rx_byte <= b;
        @(posedge clk);
        while (!in_ch.ready)
            @(posedge clk);
        // Words the block just drops are not counted toward the phase size
        counts = (b == mark_cfg) || (pg_open && b >= HEX_MIN);
        got = decode_word(b);
        if (typed)
            got = want;
        if (got.hit)
            pending_events.push_back(got);
        if (counts)
            words_sent++;
        @(negedge clk);
    endtask

    // Two hex digits, random case; now and then a sub-0x30 filler after a digit
    task automatic send_hex(input logic [7:0] v);
        logic [3:0] nib;
        logic [7:0] ch;
        logic [7:0] fill;
        for (int k = 1; k >= 0; k--)
        begin
            nib = v[4*k +: 4];
            if (nib < 4'd10)
                ch = 8'h30 + 8'(nib);
            else
                ch = ($urandom_range(0, 1) ? 8'h61 : 8'h41) + 8'(nib) - 8'd10;
            put_word(ch, 1'b0, NO_EVENT);
            fill = 8'($urandom_range(0, 8'h2f));
            if ($urandom_range(0, 24) == 0 && fill != mark_cfg)
                put_word(fill, 1'b0, NO_EVENT);
        end
    endtask

    // Sends a tag as hex; one time in eight it may be cut short
    task automatic send_tag(input logic [63:0] tag, input logic [3:0] len);
        int span;
        span = tag_span(len);
        if ($urandom_range(0, 7) == 0)
            span = $urandom_range(1, span);
        for (int i = 0; i < span; i++)
            send_hex(tag[8*i +: 8]);
    endtask

    // Mostly a page: mark and begin tag unless already open, payload, end tag, and half
    // the time a closing mark. The rest is raw noise, also knocking the digit pairing off.
    task automatic send_frame();
        int n;
        if ($urandom_range(0, 5) == 0)
        begin
            n = $urandom_range(1, 8);
            repeat (n) put_word(8'($urandom_range(0, 255)), 1'b0, NO_EVENT);
            return;
        end
        if (!pg_open)
            put_word(mark_cfg, 1'b0, NO_EVENT);
        // Realign to a digit pair unless the noise should stay in
        if (half_held && $urandom_range(0, 3) != 0)
            put_word("0", 1'b0, NO_EVENT);
        if (!cmd_open)
            send_tag(open_tag, open_len);
        n = $urandom_range(0, 6);
        repeat (n) send_hex(8'($urandom_range(0, 255)));
        send_tag(close_tag, close_len);
        if ($urandom_range(0, 1) == 1)
            put_word(mark_cfg, 1'b0, NO_EVENT);
    endtask

    // Wait until every due result is out and the pipe has emptied
    task automatic settle();
        in_ch.valid <= 1'b0;
        while (pending_events.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        @(negedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(negedge clk);
        case (idx)
            CFG_PAGE_MARK: mark_cfg  = val[7:0];
            CFG_BEGIN_TAG: open_tag  = val;
            CFG_BEGIN_LEN: open_len  = val[3:0];
            CFG_END_TAG:   close_tag = val;
            CFG_END_LEN:   close_len = val[3:0];
            default: ;
        endcase
    endtask

    task automatic load_setting(input setting_t s);
        write_reg(CFG_PAGE_MARK, 64'(s.mark));
        write_reg(CFG_BEGIN_TAG, s.open_tag);
        write_reg(CFG_BEGIN_LEN, 64'(s.open_len));
        write_reg(CFG_END_TAG, s.close_tag);
        write_reg(CFG_END_LEN, 64'(s.close_len));
        write_reg(CFG_UNMAPPED, {$urandom, $urandom});
        cfg_we <= 1'b0;
    endtask

    function automatic logic [3:0] draw_len();
        case ($urandom_range(0, 9))
            0: return 4'd0;
            1: return 4'd15;
            2: return 4'd8;
            3: return 4'($urandom_range(0, 15));
            default: return 4'($urandom_range(1, 4));
        endcase
    endfunction

    function automatic logic [63:0] draw_tag();
        case ($urandom_range(0, 7))
            0: return 64'h0;
            1: return '1;
            default: return {$urandom, $urandom};
        endcase
    endfunction

    // Page marks mostly stay clear of the hex alphabet so frames survive
    function automatic setting_t draw_setting();
        setting_t s;
        case ($urandom_range(0, 9))
            0: s.mark = 8'h00;
            1: s.mark = 8'hFF;
            2: s.mark = 8'($urandom_range(0, 255));
            default: s.mark = $urandom_range(0, 1) ? 8'($urandom_range(0, 8'h2f))
                                                   : 8'($urandom_range(8'h80, 8'hff));
        endcase
        s.open_tag  = draw_tag();
        s.open_len  = draw_len();
        s.close_tag = draw_tag();
        s.close_len = draw_len();
        return s;
    endfunction

    // ---------------------------------------------------------------
    // Event channel: random back-pressure bursts
    // ---------------------------------------------------------------
    initial
    begin : sink_pacing
        int hold;
        hold = 0;
        out_ch.ready <= 1'b0;
        forever
        begin
            @(negedge clk);
            if (idle_on && hold == 0 && $urandom_range(0, 5) == 0)
                hold = $urandom_range(1, 10);
            if (hold > 0)
            begin
                out_ch.ready <= 1'b0;
                hold--;
            end
            else
            begin
                out_ch.ready <= 1'b1;
            end
        end
    end

    // Every taken result word is matched to the oldest prediction
    always @(posedge clk)
    begin : event_check
        outcome_t due;
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            if (pending_events.size() == 0)
            begin
                report_fault($sformatf("unexpected word: kind %0d byte %02h",
                                       out_ch.event_kind, out_ch.cmd_byte));
            end
            else
            begin
                due = pending_events.pop_front();
                if (out_ch.event_kind !== due.kind)
                    report_fault($sformatf("event_kind: expected %0d, got %0d",
                                           due.kind, out_ch.event_kind));
                if (out_ch.cmd_byte !== due.data)
                    report_fault($sformatf("cmd_byte: expected %02h, got %02h",
                                           due.data, out_ch.cmd_byte));
            end
        end
    end

    // ---------------------------------------------------------------
    // Main sequence
    // ---------------------------------------------------------------
    initial
    begin : stimulus
        setting_t s;
        rst_n         <= 1'b0;
        cfg_we        <= 1'b0;
        cfg_index     <= CFG_PAGE_MARK;
        cfg_wdata     <= '0;
        in_ch.valid   <= 1'b0;
        in_ch.rx_byte <= 8'h00;

        mark_cfg  = PAGE_MARK_RST;
        open_tag  = BEGIN_TAG_RST;
        open_len  = BEGIN_LEN_RST;
        close_tag = END_TAG_RST;
        close_len = END_LEN_RST;
        pg_open   = 1'b0;
        half_held = 1'b0;
        hi_nib    = 4'd0;
        cmd_open  = 1'b0;
        mpos      = 4'd0;
        for (int i = 0; i < TAG_DEPTH; i++)
            mbuf[i] = 8'h00;

        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed table; the mid-table setup uses the register extremes
        for (int i = 0; i < DIR_ROWS; i++)
        begin
            if (i == SETUP_ROW)
            begin
                settle();
                load_setting('{8'hFF, '1, 4'd15, 64'h0, 4'd0});
            end
            put_word(dir_plan[i].b, dir_plan[i].typed, dir_plan[i].want);
        end

        // Random phases, each on fresh registers; the last two run without
        // any gaps on either side
        words_sent = 0;
        for (int ph = 0; ph < RANDOM_PHASES; ph++)
        begin
            settle();
            s = draw_setting();
            if (ph == 0)
            begin
                s.open_len  = 4'd8;
                s.close_len = 4'd8;
            end
            else if (ph == 1)
            begin
                s.open_len  = 4'd1;
                s.close_len = 4'd1;
            end
            load_setting(s);
            idle_on = (ph < RANDOM_PHASES - 2);
            while (words_sent < (ph + 1) * WORDS_PER_PHASE)
                send_frame();
        end

        in_ch.valid <= 1'b0;
        while (pending_events.size() != 0)
            @(posedge clk);
        repeat (2 * SETTLE_CYCLES) @(posedge clk);
        if (pending_events.size() != 0)
            report_fault($sformatf("%0d results never arrived", pending_events.size()));

        if (mismatches == 0)
            $display("[hex_page_command_extractor] OK");
        else
            $display("[hex_page_command_extractor] ERROR");
        $finish;
    end

    // Hard stop if the block hangs
    initial
    begin : watchdog
        #5_000_000;
        $display("[hex_page_command_extractor] ERROR");
        $finish;
    end

endmodule

[hex_page_command_extractor.f]
design/hpce_pkg.sv
design/hpce_in_if.sv
design/hpce_out_if.sv
design/hpce_front.sv
design/hpce_matcher.sv
design/hex_page_command_extractor.sv
tb/tb.sv
